// File: rtl/prt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the partition refinement table.
// Used by the front part, the back part and the top level; depends on nothing else.

package prt_pkg;

    localparam int MAX_ELEMENTS_DEF = 256;
    localparam int ELEM_W           = 8;
    localparam int UNIV_W           = 9;
    localparam int CMD_QUEUE_DEPTH  = 2;
    localparam int RES_QUEUE_DEPTH  = 2;

    localparam logic [UNIV_W-1:0] UNIVERSE_RESET = 9'd256;

    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_REFINE  = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;

    typedef enum logic [1:0] {
        OP_RESTART,
        OP_REFINE,
        OP_QUERY,
        OP_REJECT
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOKUP,
        BK_SCAN,
        BK_DONE
    } bk_state_t;

    typedef struct packed {
        op_t               op;
        logic [ELEM_W-1:0] elem_a;
        logic [ELEM_W-1:0] elem_b;
        logic              last;
        logic [UNIV_W-1:0] scan_len;
        logic              beyond;
    } cmd_t;

    typedef struct packed {
        logic              ok;
        logic [ELEM_W-1:0] class_a;
        logic              same_class;
        logic [ELEM_W-1:0] first_member;
        logic [ELEM_W-1:0] next_member;
    } res_t;

endpackage

// File: rtl/prt_fifo.sv
`timescale 1ns / 1ps
// Small synchronous queue of packed words.
// Used between the front and back parts and at the result side; needs no package.

module prt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/prt_front.sv
`timescale 1ns / 1ps
// Front part: accepts input words, range-checks them and turns them into commands.
// Holds the universe register and the latched universe; uses prt_pkg.

module prt_front import prt_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int TABLE_DEPTH  = MAX_ELEMENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        kind,
    input  logic [ELEM_W-1:0] elem_a,
    input  logic [ELEM_W-1:0] elem_b,
    input  logic              last,
    input  logic              cfg_we,
    input  logic [UNIV_W-1:0] cfg_wdata,
    input  logic              cmd_full,
    output logic              cmd_push,
    output cmd_t              cmd
);

    localparam int ACT_CAP   = (MAX_ELEMENTS > 511) ? 511 : MAX_ELEMENTS;
    localparam int ACT_RESET = (ACT_CAP < 256) ? ACT_CAP : 256;

    logic [UNIV_W-1:0] universe_reg, universe_next;
    logic [UNIV_W-1:0] active_reg, active_next;
    logic [UNIV_W-1:0] clamped;
    logic              a_in, b_in;

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;
    assign a_in     = ({1'b0, elem_a} < active_reg);
    assign b_in     = ({1'b0, elem_b} < active_reg);

    always_comb
    begin
        universe_next = cfg_we ? cfg_wdata : universe_reg;

        if (universe_reg == '0)
        begin
            clamped = UNIV_W'(1);
        end
        else if (32'(universe_reg) > ACT_CAP)
        begin
            clamped = UNIV_W'(ACT_CAP);
        end
        else
        begin
            clamped = universe_reg;
        end

        active_next = active_reg;
        cmd.elem_a  = elem_a;
        cmd.elem_b  = elem_b;
        cmd.last    = last;
        cmd.beyond  = (32'(active_reg) > TABLE_DEPTH);
        cmd.scan_len = cmd.beyond ? UNIV_W'(TABLE_DEPTH) : active_reg;

        case (kind)
            KIND_RESTART:
            begin
                cmd.op = OP_RESTART;
                if (cmd_push)
                begin
                    active_next = clamped;
                end
            end
            KIND_REFINE:
            begin
                cmd.op = a_in ? OP_REFINE : OP_REJECT;
            end
            KIND_QUERY:
            begin
                cmd.op = (a_in && b_in) ? OP_QUERY : OP_REJECT;
            end
            default:
            begin
                cmd.op = OP_REJECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            universe_reg <= UNIVERSE_RESET;
            active_reg   <= UNIV_W'(ACT_RESET);
        end
        else
        begin
            universe_reg <= universe_next;
            active_reg   <= active_next;
        end
    end

endmodule

// File: rtl/prt_back.sv
`timescale 1ns / 1ps
// Back part: carries out commands against the class table and builds result words.
// Holds the class table, its valid bits and the class total; uses prt_pkg.

module prt_back import prt_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int TABLE_DEPTH  = MAX_ELEMENTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_empty,
    output logic cmd_pop,
    output res_t res,
    output logic res_push,
    input  logic res_full
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CLS_W = $clog2(MAX_ELEMENTS);
    localparam int TOT_W = $clog2(MAX_ELEMENTS + 1);

    bk_state_t state_reg, state_next;

    logic [TOT_W-1:0]       total_reg, total_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CLS_W-1:0]       c_reg, c_next;
    cmd_t                   q_reg, q_next;
    logic [ELEM_W-1:0]      idx_reg, idx_next;
    logic                   have_first_reg, have_first_next;
    logic                   have_next_reg, have_next_next;
    logic                   same_reg, same_next;
    logic [ELEM_W-1:0]      first_reg, first_next;
    logic [ELEM_W-1:0]      next_reg, next_next;

    logic [CLS_W-1:0] table_mem [TABLE_DEPTH];
    logic [CLS_W-1:0] rd_data_reg;
    logic             rd_vld_reg;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    logic [CLS_W-1:0] entry_cls;

    assign entry_cls = rd_vld_reg ? rd_data_reg : '0;
    assign wr_addr   = cmd.elem_a[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        valid_next      = valid_reg;
        c_next          = c_reg;
        q_next          = q_reg;
        idx_next        = idx_reg;
        have_first_next = have_first_reg;
        have_next_next  = have_next_reg;
        same_next       = same_reg;
        first_next      = first_reg;
        next_next       = next_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res             = '0;
        rd_addr         = '0;
        wr_en           = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_RESTART:
                        begin
                            valid_next = '0;
                            total_next = TOT_W'(1);
                            res.ok     = 1'b1;
                            res_push   = 1'b1;
                        end
                        OP_REFINE:
                        begin
                            res_push = 1'b1;
                            if (total_reg < TOT_W'(MAX_ELEMENTS))
                            begin
                                wr_en               = 1'b1;
                                valid_next[wr_addr] = 1'b1;
                                res.ok              = 1'b1;
                                res.class_a         = ELEM_W'(total_reg);
                                if (cmd.last)
                                begin
                                    total_next = total_reg + TOT_W'(1);
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            q_next     = cmd;
                            rd_addr    = cmd.elem_a[AW-1:0];
                            state_next = BK_LOOKUP;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            BK_LOOKUP:
            begin
                c_next          = entry_cls;
                rd_addr         = '0;
                idx_next        = '0;
                have_first_next = 1'b0;
                have_next_next  = 1'b0;
                same_next       = 1'b0;
                first_next      = '0;
                next_next       = '0;
                state_next      = BK_SCAN;
            end
            BK_SCAN:
            begin
                if (entry_cls == c_reg)
                begin
                    if (!have_first_reg)
                    begin
                        have_first_next = 1'b1;
                        first_next      = idx_reg;
                    end
                    if (!have_next_reg && (idx_reg > q_reg.elem_a))
                    begin
                        have_next_next = 1'b1;
                        next_next      = idx_reg;
                    end
                    if (idx_reg == q_reg.elem_b)
                    begin
                        same_next = 1'b1;
                    end
                end
                if ({1'b0, idx_reg} == q_reg.scan_len - UNIV_W'(1))
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    idx_next = idx_reg + ELEM_W'(1);
                    rd_addr  = idx_reg[AW-1:0] + AW'(1);
                end
            end
            BK_DONE:
            begin
                if (!res_full)
                begin
                    res_push         = 1'b1;
                    res.ok           = 1'b1;
                    res.class_a      = ELEM_W'(c_reg);
                    res.same_class   = same_reg;
                    res.first_member = first_reg;
                    if (have_next_reg)
                    begin
                        res.next_member = next_reg;
                    end
                    else if (q_reg.beyond && (c_reg == '0))
                    begin
                        // Elements past the table are never refined and stay in class 0.
                        res.next_member = ELEM_W'(TABLE_DEPTH);
                    end
                    else
                    begin
                        res.next_member = first_reg;
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            total_reg <= TOT_W'(1);
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg          <= c_next;
        q_reg          <= q_next;
        idx_reg        <= idx_next;
        have_first_reg <= have_first_next;
        have_next_reg  <= have_next_next;
        same_reg       <= same_next;
        first_reg      <= first_next;
        next_reg       <= next_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= total_reg[CLS_W-1:0];
        end
        rd_data_reg <= table_mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != '0) && (total_reg <= TOT_W'(MAX_ELEMENTS)))
        else $error("Class total left its legal range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN) |-> ({1'b0, idx_reg} < q_reg.scan_len))
        else $error("Scan index ran past the scan length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN) |=> ((state_reg == BK_SCAN) || (state_reg == BK_DONE)))
        else $error("Scan left without finishing.");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (!res_full && ((state_reg == BK_IDLE) || (state_reg == BK_DONE))))
        else $error("Result pushed at the wrong time.");
`endif

endmodule

// File: rtl/partition_refinement_table.sv
`timescale 1ns / 1ps
// Top level of the partition refinement table: front part, command queue, back part
// and result queue. Depends on prt_pkg, prt_fifo, prt_front and prt_back.
//
// Channel   Direction  Handshake          Fields
// input     in         push / full        kind, elem_a, elem_b, last
// result    out        empty / pop        ok, class_a, same_class, first_member, next_member
// config    in         cfg_we             cfg_wdata (universe_size)
//
// Restart, refine and rejected words are finished in the back part's idle state.
// A query steps through the lookup, scan and done states; the scan covers min(universe,
// table depth) entries through the single read port of the class table, one entry a cycle.
// Reset and restart clear the table at once through per-entry valid bits.
// Two-entry queues sit before and after the back part, so either side may stall.

module partition_refinement_table import prt_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        kind,
    input  logic [ELEM_W-1:0] elem_a,
    input  logic [ELEM_W-1:0] elem_b,
    input  logic              last,
    output logic              empty,
    input  logic              pop,
    output logic              ok,
    output logic [ELEM_W-1:0] class_a,
    output logic              same_class,
    output logic [ELEM_W-1:0] first_member,
    output logic [ELEM_W-1:0] next_member,
    input  logic              cfg_we,
    input  logic [UNIV_W-1:0] cfg_wdata
);

    localparam int TABLE_DEPTH = (MAX_ELEMENTS < 256) ? MAX_ELEMENTS : 256;

    cmd_t front_cmd, back_cmd;
    res_t back_res, out_res;
    logic cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic res_push, res_full;

    prt_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    prt_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    prt_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (back_res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    prt_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign ok           = out_res.ok;
    assign class_a      = out_res.class_a;
    assign same_class   = out_res.same_class;
    assign first_member = out_res.first_member;
    assign next_member  = out_res.next_member;

endmodule
